// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/spf_pkg.sv =====
// ----------------------------------------------------------------------------
// spf_pkg
// Types and constants of the serial packet framer.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int PACKET_BYTES = 64;
    localparam int ADDR_W       = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
    localparam int POS_W        = $clog2(PACKET_BYTES + 13);

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] CFG_ESCAPE = 2'd0;
    localparam logic [1:0] CFG_HEADER = 2'd1;
    localparam logic [1:0] CFG_END    = 2'd2;

    localparam logic [7:0] BYTE_LF    = 8'h0a;
    localparam logic [7:0] BYTE_CR    = 8'h0d;
    localparam logic [7:0] BYTE_SPACE = 8'h20;

    localparam logic [POS_W-1:0] POS_CR   = POS_W'(PACKET_BYTES + 1);
    localparam logic [POS_W-1:0] POS_ESC1 = POS_W'(PACKET_BYTES + 2);
    localparam logic [POS_W-1:0] POS_HDR  = POS_W'(PACKET_BYTES + 3);
    localparam logic [POS_W-1:0] POS_DST  = POS_W'(PACKET_BYTES + 4);
    localparam logic [POS_W-1:0] POS_SP1  = POS_W'(PACKET_BYTES + 5);
    localparam logic [POS_W-1:0] POS_PORT = POS_W'(PACKET_BYTES + 6);
    localparam logic [POS_W-1:0] POS_END  = POS_W'(PACKET_BYTES + 10);
    localparam logic [POS_W-1:0] POS_SP2  = POS_W'(PACKET_BYTES + 11);
    localparam logic [POS_W-1:0] POS_FIN  = POS_W'(PACKET_BYTES + 12);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] index;
        logic [7:0] value;
        logic [7:0] destination;
        logic [7:0] port;
        logic [6:0] length;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       packet_done;
        logic       receiver_enable;
    } t_out_beat;

endpackage

// ===== rtl/spf_ram.sv =====
// ----------------------------------------------------------------------------
// spf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module spf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/serial_packet_framer.sv =====
// ----------------------------------------------------------------------------
// serial_packet_framer
// Frames one buffered packet for a byte-wide serial transmitter.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                 payload
//  in       in   i_in_valid / o_in_ready   i_in_data  (t_in_beat)
//  out      out  o_out_valid / i_out_ready o_out_data (t_out_beat)
//  cfg      in   i_cfg_we                  i_cfg_index, i_cfg_data
//
//  Every beat is accepted, with a buffer read, in ST_IDLE, then executed in ST_EXEC.
//  The buffer RAM read is registered; execute uses the read data.
//  One result beat per input beat; a new beat is taken in ST_IDLE once
//  the result register is empty or drains in the same cycle.
//  Synchronous active-low reset; the buffer itself is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module serial_packet_framer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  spf_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output spf_pkg::t_out_beat o_out_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    import spf_pkg::*;

    t_state           r_state, n_state;
    t_in_beat         r_item;
    t_out_beat        r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_escape, r_header, r_end;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_len, n_len;
    logic [7:0]       r_dst, n_dst;
    logic [7:0]       r_port, n_port;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic             in_accept;
    logic             ram_we;
    logic [7:0]       ram_rdata;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign ram_we = in_accept && (i_in_data.op == OP_LOAD)
                    && (32'(i_in_data.index) < PACKET_BYTES);

    spf_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(i_in_data.index)),
        .i_wdata (i_in_data.value),
        .i_raddr (r_pos[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape <= '0;
            r_header <= '0;
            r_end    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ESCAPE: r_escape <= i_cfg_data;
                CFG_HEADER: r_header <= i_cfg_data;
                CFG_END:    r_end    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_pos       <= POS_FIN;
            r_len       <= '0;
            r_dst       <= '0;
            r_port      <= '0;
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_dst       <= n_dst;
            r_port      <= n_port;
            r_busy      <= n_busy;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in_data;
        end
        if (r_state == ST_EXEC) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_pos       = r_pos;
        n_len       = r_len;
        n_dst       = r_dst;
        n_port      = r_port;
        n_busy      = r_busy;
        n_done      = r_done;
        n_out       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
                case (r_item.op)
                    OP_START: begin
                        n_dst  = r_item.destination;
                        n_port = r_item.port;
                        if (32'(r_item.length) > PACKET_BYTES) begin
                            n_len = POS_W'(PACKET_BYTES);
                        end else begin
                            n_len = POS_W'(r_item.length);
                        end
                        n_done         = 1'b0;
                        n_busy         = 1'b1;
                        n_pos          = POS_CR;
                        n_out.tx_byte  = BYTE_LF;
                        n_out.tx_valid = 1'b1;
                    end
                    OP_TICK: begin
                        if (r_busy) begin
                            n_out.tx_valid = 1'b1;
                            case (r_pos)
                                POS_CR: begin
                                    n_out.tx_byte = BYTE_CR;
                                    n_pos         = POS_ESC1;
                                end
                                POS_ESC1: begin
                                    n_out.tx_byte = r_escape;
                                    n_pos         = POS_HDR;
                                end
                                POS_HDR: begin
                                    n_out.tx_byte = r_header;
                                    n_pos         = POS_DST;
                                end
                                POS_DST: begin
                                    n_out.tx_byte = r_dst;
                                    n_pos         = POS_SP1;
                                end
                                POS_SP1: begin
                                    n_out.tx_byte = BYTE_SPACE;
                                    n_pos         = POS_PORT;
                                end
                                POS_PORT: begin
                                    n_out.tx_byte = r_port;
                                    n_pos         = '0;
                                end
                                POS_END: begin
                                    n_out.tx_byte = r_end;
                                    n_pos         = POS_SP2;
                                end
                                POS_SP2: begin
                                    n_out.tx_byte = BYTE_SPACE;
                                    n_pos         = POS_FIN;
                                end
                                POS_FIN: begin
                                    n_out.tx_valid        = 1'b0;
                                    n_out.receiver_enable = 1'b1;
                                    n_done                = 1'b1;
                                    n_busy                = 1'b0;
                                end
                                default: begin
                                    if ((r_pos < r_len) && (32'(r_pos) < PACKET_BYTES)) begin
                                        n_out.tx_byte = ram_rdata;
                                        n_pos         = r_pos + POS_W'(1);
                                    end else begin
                                        n_out.tx_byte = r_escape;
                                        n_pos         = POS_END;
                                    end
                                end
                            endcase
                        end
                    end
                    default: ;
                endcase
                n_out.packet_done = n_done;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, in_accept, r_state == ST_EXEC,
        "accepted beat did not enter execute")
    `ASSERT_NEXT(a_exec_result, i_clk, i_rst_n, r_state == ST_EXEC, r_out_valid,
        "execute cycle produced no result beat")
    `ASSERT_IMPL(a_finish_flags, i_clk, i_rst_n, r_out_valid && r_out.receiver_enable,
        r_out.packet_done && !r_out.tx_valid && !r_busy,
        "frame finish beat inconsistent with done and busy")

endmodule
